>>> sv/adam_optimizer_update_core_macros.svh
// Assertion macros for the Adam update core.
// Included by the files that carry concurrent checks; no other dependency.
`ifndef ADAM_OPTIMIZER_UPDATE_CORE_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Check sampled on clk_i, masked while rst_ni is low
`define AOU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("adam update core: check failed");
// Check sampled on clk_i that also holds during reset
`define AOU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("adam update core: check failed");
`else
`define AOU_ASSERT(lbl, prop)
`define AOU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/aou_pkg.sv
// Shared widths, constants, register codes and structs of the Adam update core.
// No dependencies; used by the interfaces, the moment stage, the core and the bench.
package aou_pkg;

  localparam int IDX_W    = 12;
  localparam int VAL_W    = 32;
  localparam int BETA_W   = 24;
  localparam int POW_W    = 25;
  localparam int LR_W     = 32;
  localparam int EPS_W    = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int PARAM_COUNT_DEF = 4096;

  // Q1.24 one and half
  localparam logic [POW_W-1:0] ONE_Q24  = 25'h100_0000;
  localparam logic [POW_W-1:0] HALF_Q24 = 25'h080_0000;

  // register reset values
  localparam logic [LR_W-1:0]   STEP_SIZE_RST = 32'd4294967;
  localparam logic [BETA_W-1:0] BETA_ONE_RST  = 24'd15099494;
  localparam logic [BETA_W-1:0] BETA_TWO_RST  = 24'd16760438;
  localparam logic [EPS_W-1:0]  EPSILON_RST   = 32'd43;

  // datapath widths
  localparam int MHAT_Q_W   = 32;
  localparam int MHAT_NUM_W = 56;
  localparam int VHAT_Q_W   = 56;
  localparam int VHAT_NUM_W = 57;
  localparam int ROOT_IN_W  = 56;
  localparam int ROOT_SHIFT = 48;
  localparam int ROOT_W     = (ROOT_IN_W + ROOT_SHIFT) / 2;
  localparam int DEN_W      = ROOT_W + 1;
  localparam int STEP_Q_W   = 34;
  localparam int STEP_NUM_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE,
    CFG_BETA_ONE,
    CFG_BETA_TWO,
    CFG_EPSILON
  } aou_cfg_reg_e;

  typedef struct packed {
    logic [LR_W-1:0]   step_size;
    logic [BETA_W-1:0] beta_one;
    logic [BETA_W-1:0] beta_two;
    logic [EPS_W-1:0]  epsilon_term;
  } aou_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] grad;
    logic signed [VAL_W-1:0] param;
  } aou_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] param;
    logic signed [VAL_W-1:0] m;
    logic [VAL_W-1:0]        v;
    logic [POW_W-1:0]        bc1;
    logic [POW_W-1:0]        bc2;
    logic                    sat;
    logic                    oor;
  } aou_mom_t;

  // per-item sideband carried through the arithmetic pipeline
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] param;
    logic                    neg;
    logic                    sat;
    logic                    oor;
  } aou_tag_t;

  typedef struct packed {
    aou_tag_t         tag;
    logic [VAL_W-1:0] v;
    logic [POW_W-1:0] bc2;
    logic             ovf;
  } aou_d1_side_t;

  typedef struct packed {
    aou_tag_t         tag;
    logic [VAL_W-1:0] mhat;
  } aou_d2_side_t;

  typedef struct packed {
    aou_tag_t tag;
    logic     ovf;
  } aou_d3_side_t;

endpackage

>>> sv/aou_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on aou_pkg for field widths.
interface aou_in_if;
  logic                             valid;
  logic                             ready;
  logic [aou_pkg::IDX_W-1:0]        element_index;
  logic signed [aou_pkg::VAL_W-1:0] gradient;
  logic signed [aou_pkg::VAL_W-1:0] param_value;
  logic                             step_start;

  modport source (output valid, element_index, gradient, param_value, step_start,
                  input ready);
  modport sink   (input valid, element_index, gradient, param_value, step_start,
                  output ready);
endinterface

interface aou_out_if;
  logic                             valid;
  logic                             ready;
  logic [aou_pkg::IDX_W-1:0]        out_index;
  logic signed [aou_pkg::VAL_W-1:0] new_param;
  logic                             saturated;

  modport source (output valid, out_index, new_param, saturated, input ready);
  modport sink   (input valid, out_index, new_param, saturated, output ready);
endinterface

>>> sv/aou_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; the caller guarantees the high numerator part is below the divisor.
module aou_div #(
  parameter int NUM_W  = 56,
  parameter int DEN_W  = 25,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [QUO_W-1:0]  vld_q;
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  sh_q   [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic              in_vld;
    logic [DEN_W-1:0]  in_rem;
    logic [QUO_W-1:0]  in_sh;
    logic [DEN_W-1:0]  in_den;
    logic [SIDE_W-1:0] in_side;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign in_vld  = vld_i;
      assign in_rem  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign in_sh   = num_i[QUO_W-1:0];
      assign in_den  = den_i;
      assign in_side = side_i;
    end else begin : g_next
      assign in_vld  = vld_q[s-1];
      assign in_rem  = rem_q[s-1];
      assign in_sh   = sh_q[s-1];
      assign in_den  = den_q[s-1];
      assign in_side = side_q[s-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {in_rem, in_sh[QUO_W-1]};
    assign ge    = trial >= {1'b0, in_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? DEN_W'(trial - {1'b0, in_den}) : DEN_W'(trial);
        sh_q[s]   <= {in_sh[QUO_W-2:0], ge};
        den_q[s]  <= in_den;
        side_q[s] <= in_side;
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign quo_o  = sh_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

>>> sv/aou_sqrt.sv
// Pipelined integer square root of rad_i * 2^SHIFT_W, one root bit per stage.
// Standalone; carries a sideband word alongside each operand.
module aou_sqrt #(
  parameter int IN_W   = 56,
  parameter int SHIFT_W = 48,
  parameter int SIDE_W = 8,
  localparam int RT_W  = (IN_W + SHIFT_W) / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [RT_W-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [RT_W-1:0]   vld_q;
  logic [IN_W-1:0]   rad_q  [RT_W];
  logic [RT_W+1:0]   rem_q  [RT_W];
  logic [RT_W-1:0]   root_q [RT_W];
  logic [SIDE_W-1:0] side_q [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    logic              in_vld;
    logic [IN_W-1:0]   in_rad;
    logic [RT_W+1:0]   in_rem;
    logic [RT_W-1:0]   in_root;
    logic [SIDE_W-1:0] in_side;
    logic [RT_W+1:0]   r_sh;
    logic [RT_W+1:0]   trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign in_vld  = vld_i;
      assign in_rad  = rad_i;
      assign in_rem  = '0;
      assign in_root = '0;
      assign in_side = side_i;
    end else begin : g_next
      assign in_vld  = vld_q[s-1];
      assign in_rad  = rad_q[s-1];
      assign in_rem  = rem_q[s-1];
      assign in_root = root_q[s-1];
      assign in_side = side_q[s-1];
    end

    // bring down two radicand bits (zeros once the operand is used up)
    assign r_sh  = {in_rem[RT_W-1:0], in_rad[IN_W-1 -: 2]};
    assign trial = {in_root, 2'b01};
    assign ge    = r_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= {in_rad[IN_W-3:0], 2'b00};
        rem_q[s]  <= ge ? r_sh - trial : r_sh;
        root_q[s] <= {in_root[RT_W-2:0], ge};
        side_q[s] <= in_side;
      end
    end
  end

  assign vld_o  = vld_q[RT_W-1];
  assign root_o = root_q[RT_W-1];
  assign side_o = side_q[RT_W-1];

endmodule

>>> sv/aou_moment.sv
// Moment memories with clearing pass, read-modify-write and forwarding.
// Depends on aou_pkg and the assertion macro header.
`include "adam_optimizer_update_core_macros.svh"

module aou_moment #(
  parameter int PARAM_COUNT = aou_pkg::PARAM_COUNT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      acc_i,
  input  aou_pkg::aou_item_t        item_i,
  input  aou_pkg::aou_cfg_t         cfg_i,
  input  logic [aou_pkg::POW_W-1:0] bc1_i,
  input  logic [aou_pkg::POW_W-1:0] bc2_i,
  output logic                      busy_o,
  output logic                      vld_o,
  output aou_pkg::aou_mom_t         mom_o
);
  import aou_pkg::*;

  localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PARAM_COUNT - 1);

  logic signed [VAL_W-1:0] mem_m [PARAM_COUNT];
  logic [VAL_W-1:0]        mem_v [PARAM_COUNT];

  // clearing pass
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // read / update stage
  logic                    s1_vld_q;
  logic [IDX_W-1:0]        s1_idx_q;
  logic signed [VAL_W-1:0] s1_grad_q;
  logic signed [VAL_W-1:0] s1_param_q;
  logic [VAL_W-1:0]        s1_gsq_q;
  logic                    s1_gsat_q;
  logic                    s1_oor_q;
  logic signed [VAL_W-1:0] rd_m_q;
  logic [VAL_W-1:0]        rd_v_q;

  // last write, for an element read while it was being written
  logic                    fw_vld_q;
  logic [IDX_W-1:0]        fw_idx_q;
  logic signed [VAL_W-1:0] fw_m_q;
  logic [VAL_W-1:0]        fw_v_q;

  logic                    vld_q;
  aou_mom_t                mom_q;

  logic [VAL_W-1:0]        gmag;
  logic [2*VAL_W-1:0]      gsq_full;
  logic                    item_oor;
  logic [AW-1:0]           rd_addr;

  logic signed [VAL_W-1:0] m_old;
  logic [VAL_W-1:0]        v_old;
  logic                    fw_hit;
  logic [POW_W-1:0]        nb1, nb2;
  logic signed [57:0]      m_prod_a, m_prod_b;
  logic signed [58:0]      m_sum;
  logic signed [VAL_W-1:0] m_new;
  logic [55:0]             v_prod_a;
  logic [56:0]             v_prod_b;
  logic [57:0]             v_sum;
  logic [VAL_W-1:0]        v_new;
  logic                    wr_en;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wm;
  logic [VAL_W-1:0]        mem_wv;

  // clear sequencer
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST_ADDR) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign busy_o = clr_q;

  // squared gradient at capture
  assign gmag     = item_i.grad[VAL_W-1] ? VAL_W'(-item_i.grad) : VAL_W'(item_i.grad);
  assign gsq_full = (2*VAL_W)'(gmag) * (2*VAL_W)'(gmag) + (2*VAL_W)'(32768);
  assign item_oor = (32'(item_i.idx) >= PARAM_COUNT);
  assign rd_addr  = AW'(item_i.idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_idx_q   <= item_i.idx;
      s1_grad_q  <= item_i.grad;
      s1_param_q <= item_i.param;
      s1_gsq_q   <= (gsq_full[63:48] != '0) ? '1 : gsq_full[47:16];
      s1_gsat_q  <= (gsq_full[63:48] != '0);
      s1_oor_q   <= item_oor;
    end
  end

  // moment update
  assign fw_hit = fw_vld_q && (fw_idx_q == s1_idx_q);
  assign m_old  = fw_hit ? fw_m_q : rd_m_q;
  assign v_old  = fw_hit ? fw_v_q : rd_v_q;
  assign nb1    = ONE_Q24 - POW_W'(cfg_i.beta_one);
  assign nb2    = ONE_Q24 - POW_W'(cfg_i.beta_two);

  always_comb begin
    m_prod_a = $signed({2'b00, cfg_i.beta_one}) * m_old;
    m_prod_b = $signed({1'b0, nb1}) * s1_grad_q;
    m_sum    = 59'(m_prod_a) + 59'(m_prod_b) + 59'sd8388608;
    m_new    = VAL_W'(m_sum >>> 24);
    v_prod_a = 56'(cfg_i.beta_two) * 56'(v_old);
    v_prod_b = 57'(nb2) * 57'(s1_gsq_q);
    v_sum    = 58'(v_prod_a) + 58'(v_prod_b) + 58'(HALF_Q24);
    v_new    = v_sum[55:24];
  end

  assign wr_en     = en_i && s1_vld_q && !s1_oor_q;
  assign mem_we    = clr_q || wr_en;
  assign mem_waddr = clr_q ? clr_cnt_q : AW'(s1_idx_q);
  assign mem_wm    = clr_q ? '0 : m_new;
  assign mem_wv    = clr_q ? '0 : v_new;

  // moment memories: one write and one read port each
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_m[mem_waddr] <= mem_wm;
      mem_v[mem_waddr] <= mem_wv;
    end
    if (acc_i) begin
      rd_m_q <= mem_m[rd_addr];
      rd_v_q <= mem_v[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_vld_q <= 1'b0;
    end else if (wr_en) begin
      fw_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fw_idx_q <= s1_idx_q;
      fw_m_q   <= m_new;
      fw_v_q   <= v_new;
    end
  end

  // hand-off register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mom_q.idx   <= s1_idx_q;
      mom_q.param <= s1_param_q;
      mom_q.m     <= m_new;
      mom_q.v     <= v_new;
      mom_q.bc1   <= bc1_i;
      mom_q.bc2   <= bc2_i;
      mom_q.sat   <= s1_gsat_q;
      mom_q.oor   <= s1_oor_q;
    end
  end

  assign vld_o = vld_q;
  assign mom_o = mom_q;

  `AOU_ASSERT(a_clear_once, !clr_q |=> !clr_q)
  `AOU_ASSERT(a_no_beat_in_clear, acc_i |-> !clr_q)
  `AOU_ASSERT(a_fwd_after_write, (wr_en && !clr_q) |=> fw_vld_q)

endmodule

>>> sv/adam_optimizer_update_core.sv
// Adam update core: takes one element beat per cycle once the moment memories are
// cleared (a pass over all PARAM_COUNT addresses after reset, no input beat taken
// meanwhile). Each beat passes a moment read-modify-write stage and then a
// pipeline of one-bit-per-stage units (32-stage mhat divider, 56-stage vhat divider,
// 52-stage square root, 34-stage step divider). The moment memories' single write
// port and forwarding of the last write set the one beat per cycle rate; a full
// output register that is not being read holds the pipeline only when its last
// stage carries a result.
`include "adam_optimizer_update_core_macros.svh"

module adam_optimizer_update_core #(
  parameter int PARAM_COUNT = aou_pkg::PARAM_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aou_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [aou_pkg::CFG_W-1:0]     cfg_wdata_i,
  aou_in_if.sink                        in_if,
  aou_out_if.source                     out_if
);
  import aou_pkg::*;

  aou_cfg_t         cfg_q;
  logic [POW_W-1:0] pow1_q, pow2_q;
  logic [49:0]      p1_sum, p2_sum;
  logic [POW_W-1:0] bc1, bc2;

  logic      en, acc, busy, load;
  aou_item_t item;
  logic      mom_vld;
  aou_mom_t  mom;

  // stage between moments and mhat divider
  logic [VAL_W-1:0]      mmag;
  logic [MHAT_NUM_W-1:0] num1;
  aou_d1_side_t          d1_side_in, d1_side_out;
  logic                  d1_vld;
  logic [MHAT_Q_W-1:0]   d1_quo;

  logic [VAL_W-1:0]      lim, mhat_c;
  logic                  clip1;
  logic [VHAT_NUM_W-1:0] num2;
  aou_d2_side_t          d2_side_in, d2_side_out, rt_side_out;
  logic                  d2_vld, rt_vld;
  logic [VHAT_Q_W-1:0]   vhat;
  logic [ROOT_W-1:0]     root;

  logic                  mu_vld_q;
  logic [DEN_W-1:0]      mu_den_q, den_sum;
  logic [STEP_NUM_W-1:0] mu_prod_q;
  aou_tag_t              mu_tag_q;

  logic [STEP_NUM_W-1:0] num3;
  aou_d3_side_t          d3_side_in, d3_side_out;
  logic                  d3_vld;
  logic [STEP_Q_W-1:0]   d3_quo, u;
  logic signed [35:0]    p_ext, u_ext, res;

  logic                    out_vld_q;
  logic [IDX_W-1:0]        out_idx_q, out_idx_d;
  logic signed [VAL_W-1:0] out_param_q, out_param_d;
  logic                    out_sat_q, out_sat_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size    <= STEP_SIZE_RST;
      cfg_q.beta_one     <= BETA_ONE_RST;
      cfg_q.beta_two     <= BETA_TWO_RST;
      cfg_q.epsilon_term <= EPSILON_RST;
    end else if (cfg_we_i) begin
      case (aou_cfg_reg_e'(cfg_idx_i))
        CFG_STEP_SIZE: cfg_q.step_size    <= cfg_wdata_i;
        CFG_BETA_ONE:  cfg_q.beta_one     <= cfg_wdata_i[BETA_W-1:0];
        CFG_BETA_TWO:  cfg_q.beta_two     <= cfg_wdata_i[BETA_W-1:0];
        CFG_EPSILON:   cfg_q.epsilon_term <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result is blocked
  assign en    = !out_vld_q || out_if.ready || !d3_vld;
  assign in_if.ready = en && !busy;
  assign acc   = in_if.valid && in_if.ready;

  // running beta powers, advanced on a step start beat
  assign p1_sum = 50'(pow1_q) * 50'(cfg_q.beta_one) + 50'(HALF_Q24);
  assign p2_sum = 50'(pow2_q) * 50'(cfg_q.beta_two) + 50'(HALF_Q24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow1_q <= ONE_Q24;
      pow2_q <= ONE_Q24;
    end else if (acc && in_if.step_start) begin
      pow1_q <= p1_sum[48:24];
      pow2_q <= p2_sum[48:24];
    end
  end

  // bias correction terms, no correction before the first step
  assign bc1 = (pow1_q == ONE_Q24) ? ONE_Q24 : ONE_Q24 - pow1_q;
  assign bc2 = (pow2_q == ONE_Q24) ? ONE_Q24 : ONE_Q24 - pow2_q;

  assign item.idx   = in_if.element_index;
  assign item.grad  = in_if.gradient;
  assign item.param = in_if.param_value;

  aou_moment #(
    .PARAM_COUNT(PARAM_COUNT)
  ) u_moment (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .acc_i  (acc),
    .item_i (item),
    .cfg_i  (cfg_q),
    .bc1_i  (bc1),
    .bc2_i  (bc2),
    .busy_o (busy),
    .vld_o  (mom_vld),
    .mom_o  (mom)
  );

  // mhat = |m| * 2^24 / bc1, rounded
  assign mmag = mom.m[VAL_W-1] ? VAL_W'(-mom.m) : VAL_W'(mom.m);
  assign num1 = {mmag, 24'd0} + MHAT_NUM_W'(mom.bc1 >> 1);

  always_comb begin
    d1_side_in.tag.idx   = mom.idx;
    d1_side_in.tag.param = mom.param;
    d1_side_in.tag.neg   = mom.m[VAL_W-1];
    d1_side_in.tag.sat   = mom.sat;
    d1_side_in.tag.oor   = mom.oor;
    d1_side_in.v         = mom.v;
    d1_side_in.bc2       = mom.bc2;
    d1_side_in.ovf       = {1'b0, num1[MHAT_NUM_W-1:MHAT_Q_W]} >= mom.bc1;
  end

  aou_div #(
    .NUM_W  (MHAT_NUM_W),
    .DEN_W  (POW_W),
    .QUO_W  (MHAT_Q_W),
    .SIDE_W ($bits(aou_d1_side_t))
  ) u_div_mhat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (mom_vld),
    .num_i  (num1),
    .den_i  (mom.bc1),
    .side_i (d1_side_in),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side_out)
  );

  // clip mhat to the signed range, then vhat = v * 2^24 / bc2
  assign lim    = d1_side_out.tag.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign clip1  = d1_side_out.ovf || (d1_quo > lim);
  assign mhat_c = clip1 ? lim : d1_quo;
  assign num2   = VHAT_NUM_W'({d1_side_out.v, 24'd0}) + VHAT_NUM_W'(d1_side_out.bc2 >> 1);

  always_comb begin
    d2_side_in.tag     = d1_side_out.tag;
    d2_side_in.tag.sat = d1_side_out.tag.sat || clip1;
    d2_side_in.mhat    = mhat_c;
  end

  aou_div #(
    .NUM_W  (VHAT_NUM_W),
    .DEN_W  (POW_W),
    .QUO_W  (VHAT_Q_W),
    .SIDE_W ($bits(aou_d2_side_t))
  ) u_div_vhat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d1_vld),
    .num_i  (num2),
    .den_i  (d1_side_out.bc2),
    .side_i (d2_side_in),
    .vld_o  (d2_vld),
    .quo_o  (vhat),
    .side_o (d2_side_out)
  );

  aou_sqrt #(
    .IN_W    (ROOT_IN_W),
    .SHIFT_W (ROOT_SHIFT),
    .SIDE_W  ($bits(aou_d2_side_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d2_vld),
    .rad_i  (vhat),
    .side_i (d2_side_out),
    .vld_o  (rt_vld),
    .root_o (root),
    .side_o (rt_side_out)
  );

  // denominator and lr * mhat
  assign den_sum = DEN_W'(root) + DEN_W'(cfg_q.epsilon_term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q <= 1'b0;
    end else if (en) begin
      mu_vld_q <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_den_q  <= (den_sum == '0) ? DEN_W'(1) : den_sum;
      mu_prod_q <= STEP_NUM_W'(cfg_q.step_size) * STEP_NUM_W'(rt_side_out.mhat);
      mu_tag_q  <= rt_side_out.tag;
    end
  end

  // u = (lr * mhat + D/2) / D
  assign num3           = mu_prod_q + STEP_NUM_W'(mu_den_q >> 1);
  assign d3_side_in.tag = mu_tag_q;
  assign d3_side_in.ovf = DEN_W'(num3[STEP_NUM_W-1:STEP_Q_W]) >= mu_den_q;

  aou_div #(
    .NUM_W  (STEP_NUM_W),
    .DEN_W  (DEN_W),
    .QUO_W  (STEP_Q_W),
    .SIDE_W ($bits(aou_d3_side_t))
  ) u_div_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (mu_vld_q),
    .num_i  (num3),
    .den_i  (mu_den_q),
    .side_i (d3_side_in),
    .vld_o  (d3_vld),
    .quo_o  (d3_quo),
    .side_o (d3_side_out)
  );

  // apply the step and saturate; a huge step saturates either way unless the index is out of range
  assign u     = d3_side_out.ovf ? '1 : d3_quo;
  assign p_ext = 36'(d3_side_out.tag.param);
  assign u_ext = $signed({2'b00, u});
  assign res   = d3_side_out.tag.neg ? p_ext + u_ext : p_ext - u_ext;

  always_comb begin
    out_idx_d   = d3_side_out.tag.idx;
    out_param_d = VAL_W'(res);
    out_sat_d   = d3_side_out.tag.sat;
    if (res > 36'sd2147483647) begin
      out_param_d = 32'sh7FFF_FFFF;
      out_sat_d   = 1'b1;
    end else if (res < -36'sd2147483648) begin
      out_param_d = 32'sh8000_0000;
      out_sat_d   = 1'b1;
    end
    if (d3_side_out.tag.oor) begin
      out_param_d = d3_side_out.tag.param;
      out_sat_d   = 1'b0;
    end
  end

  // output register
  assign load = en && d3_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q   <= out_idx_d;
      out_param_q <= out_param_d;
      out_sat_q   <= out_sat_d;
    end
  end

  assign out_if.valid     = out_vld_q;
  assign out_if.out_index = out_idx_q;
  assign out_if.new_param = out_param_q;
  assign out_if.saturated = out_sat_q;

  `AOU_ASSERT(a_pow_bound, (pow1_q <= ONE_Q24) && (pow2_q <= ONE_Q24))
  `AOU_ASSERT(a_pow_decays, (acc && in_if.step_start) |=> (pow1_q <= $past(pow1_q)))
  `AOU_ASSERT(a_no_overwrite, (out_vld_q && !out_if.ready) |-> !load)

endmodule

>>> bench/adam_optimizer_update_core_tb.sv
// Self-checking bench for the Adam update core: predicts each result beat from
// the accepted element beats and compares field by field. Depends on aou_pkg,
// the channel interfaces in aou_if.sv and the core itself.
`timescale 1ns / 1ps

module adam_optimizer_update_core_tb;
  import aou_pkg::*;

  localparam int NUM_ELEM   = 4096;
  localparam int LATENCY    = 178;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] new_param;
    logic             sat;
  } update_t;

  // Adam predictor with its own copy of moments, powers and registers
  class adam_scoreboard;
    longint unsigned lr, b1, b2, eps, pow1, pow2;
    int              mom1 [NUM_ELEM];
    int unsigned     mom2 [NUM_ELEM];
    update_t         pending [$];
    int              errors;
    int              checked;

    function void clear();
      foreach (mom1[i]) begin
        mom1[i] = 0;
        mom2[i] = 0;
      end
      pow1 = 64'd16777216;
      pow2 = 64'd16777216;
      lr = STEP_SIZE_RST;
      b1 = BETA_ONE_RST;
      b2 = BETA_TWO_RST;
      eps = EPSILON_RST;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(aou_cfg_reg_e r, logic [CFG_W-1:0] d);
      case (r)
        CFG_STEP_SIZE: lr = d;
        CFG_BETA_ONE:  b1 = d[BETA_W-1:0];
        CFG_BETA_TWO:  b2 = d[BETA_W-1:0];
        CFG_EPSILON:   eps = d;
        default: ;
      endcase
    endfunction

    // floor square root of a 128-bit value, bit by bit
    function longint unsigned isqrt(logic [127:0] x);
      logic [127:0] q, r, t;
      q = 0;
      r = 0;
      for (int k = 63; k >= 0; k--) begin
        r = (r << 2) | ((x >> (2 * k)) & 128'd3);
        t = (q << 2) | 128'd1;
        if (r >= t) begin
          r = r - t;
          q = (q << 1) | 128'd1;
        end else begin
          q = q << 1;
        end
      end
      return q[63:0];
    endfunction

    function void note_element(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] g,
                               logic signed [VAL_W-1:0] p, logic st);
      update_t         u;
      longint          m, res, mix;
      longint unsigned gmag, gsq, v, bc1, bc2, mmag, mhat, lim, vhat, den, stp;
      logic [127:0]    num;
      logic            neg;
      if (st) begin
        pow1 = (pow1 * b1 + 64'd8388608) >> 24;
        pow2 = (pow2 * b2 + 64'd8388608) >> 24;
      end
      u.idx = idx;
      u.sat = 1'b0;
      // first moment, rounded convex mix
      mix = longint'(b1) * mom1[idx] + longint'(64'd16777216 - b1) * longint'(g)
            + 64'sd8388608;
      m = mix >>> 24;
      mom1[idx] = int'(m);
      gmag = (g < 0) ? longint'(-longint'(g)) : longint'(g);
      gsq = (gmag * gmag + 64'd32768) >> 16;
      if (gsq > 64'hFFFF_FFFF) begin
        gsq = 64'hFFFF_FFFF;
        u.sat = 1'b1;
      end
      v = (b2 * mom2[idx] + (64'd16777216 - b2) * gsq + 64'd8388608) >> 24;
      mom2[idx] = v[31:0];
      bc1 = 64'd16777216 - pow1;
      bc2 = 64'd16777216 - pow2;
      if (bc1 == 0) bc1 = 64'd16777216;
      if (bc2 == 0) bc2 = 64'd16777216;
      neg = m < 0;
      mmag = neg ? longint'(-m) : longint'(m);
      mhat = ((mmag << 24) + (bc1 >> 1)) / bc1;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (mhat > lim) begin
        mhat = lim;
        u.sat = 1'b1;
      end
      vhat = ((v << 24) + (bc2 >> 1)) / bc2;
      num = 128'(vhat) << 48;
      den = isqrt(num) + eps;
      if (den == 0) den = 1;
      num = 128'(lr) * 128'(mhat) + 128'(den >> 1);
      num = num / 128'(den);
      stp = (num > 128'd8589934592) ? 64'd8589934592 : num[63:0];
      res = neg ? longint'(p) + longint'(stp) : longint'(p) - longint'(stp);
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        u.sat = 1'b1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        u.sat = 1'b1;
      end
      u.new_param = res[31:0];
      pending.insert(pending.size(), u);
    endfunction

    task check_result(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] np, logic s);
      update_t e;
      checked++;
      if (pending.size() == 0) begin
        report_err("result beat with nothing outstanding", 0, idx);
        return;
      end
      e = pending.pop_front();
      if (idx !== e.idx) report_err("out_index", e.idx, idx);
      if (np !== e.new_param) report_err("new_param", e.new_param, np);
      if (s !== e.sat) report_err("saturated", e.sat, s);
    endtask

    task report_err(string what, longint unsigned exp_v, longint unsigned got);
      errors++;
      $display("MISMATCH %s: expected 0x%0h got 0x%0h (result %0d)", what, exp_v, got,
               checked);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  aou_in_if  elem_ch ();
  aou_out_if upd_ch ();

  adam_optimizer_update_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .in_if(elem_ch.sink), .out_if(upd_ch.source)
  );

  adam_scoreboard sb;
  bit  quiet_tail;   // no idling near the end
  bit  hold_off;     // long receiver stall
  int  idle_cycles;
  int  beats_in;
  int  step_count;
  int  gap_left;
  int  stall_left;

  // frequently reused indexes, including both ends of the index range
  logic [IDX_W-1:0] hot_idx [8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stall bursts, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (upd_ch.valid && upd_ch.ready)
        sb.check_result(upd_ch.out_index, upd_ch.new_param, upd_ch.saturated);
      if (hold_off) begin
        upd_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        upd_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
        stall_left   <= $urandom_range(1, 13) - 1;
        upd_ch.ready <= 1'b0;
      end else begin
        upd_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((elem_ch.valid && elem_ch.ready) || (upd_ch.valid && upd_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT + 5000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_cfg(aou_cfg_reg_e r, logic [CFG_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(r, d);
  endtask

  // stop offering beats, then wait for every result to come back
  task automatic wait_drained();
    elem_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // one element beat, with an optional random gap before it
  task automatic send_element(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] g,
                              logic [VAL_W-1:0] p, logic st);
    if (!quiet_tail && gap_left == 0 && $urandom_range(0, 14) == 0)
      gap_left = $urandom_range(1, 13);
    while (gap_left > 0) begin
      elem_ch.valid <= 1'b0;
      gap_left--;
      @(posedge clk_i);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.element_index <= idx;
    elem_ch.gradient      <= g;
    elem_ch.param_value   <= p;
    elem_ch.step_start    <= st;
    @(posedge clk_i);
    while (!elem_ch.ready) @(posedge clk_i);
    sb.note_element(idx, g, p, st);
    beats_in++;
    if (st) step_count++;
  endtask

  task automatic idle_input();
    elem_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random gradient or parameter: mostly modest, sometimes full range
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {{14{1'b0}}, 18'($urandom())};
      2: return -{{14{1'b0}}, 18'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {{8{1'b0}}, 24'($urandom())} - 32'h0080_0000;
    endcase
  endfunction

  // a training pass, mostly over the hot indexes, step flag on its first element and now and then on others
  task automatic train_pass(int n);
    for (int i = 0; i < n; i++)
      send_element($urandom_range(0, 3) == 0 ? 12'($urandom()) : hot_idx[$urandom_range(0, 7)],
                   rand_value(), rand_value(), i == 0 || $urandom_range(0, 40) == 0);
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_STEP_SIZE;
    cfg_wdata_i = '0;
    elem_ch.valid = 1'b0;
    elem_ch.element_index = '0;
    elem_ch.gradient = '0;
    elem_ch.param_value = '0;
    elem_ch.step_start = 1'b0;
    quiet_tail = 1'b0;
    hold_off = 1'b0;
    idle_cycles = 0;
    beats_in = 0;
    step_count = 0;
    gap_left = 0;
    foreach (hot_idx[i]) hot_idx[i] = 12'($urandom());
    hot_idx[0] = 12'd0;
    hot_idx[1] = 12'hFFF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: starting before any step (no bias correction), field extremes
    send_element(12'd0, 32'h0001_0000, 32'h0000_0000, 1'b0);
    send_element(12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_element(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_element(12'd0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    send_element(12'h555, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    send_element(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_element(12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    wait_drained();

    // zero epsilon and a zero second moment: the clamped denominator
    write_cfg(CFG_EPSILON, 32'd0);
    write_cfg(CFG_BETA_TWO, 24'hFFFFFF);
    send_element(12'h123, 32'h0000_0000, 32'h0000_1000, 1'b1);
    send_element(12'h124, 32'h0000_0001, 32'h0000_1000, 1'b0);
    send_element(12'h123, 32'hFFFF_FFFF, 32'h0000_1000, 1'b0);
    wait_drained();

    // extreme register settings
    write_cfg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
    write_cfg(CFG_BETA_ONE, 24'd0);
    write_cfg(CFG_BETA_TWO, 24'd0);
    write_cfg(CFG_EPSILON, 32'hFFFF_FFFF);
    send_element(12'h321, 32'h7FFF_FFFF, 32'h0, 1'b1);
    send_element(12'h321, 32'h8000_0000, 32'h0, 1'b1);
    send_element(12'h0F0, 32'h0100_0000, 32'h7FFF_0000, 1'b0);
    wait_drained();
    write_cfg(CFG_STEP_SIZE, 32'd0);
    write_cfg(CFG_BETA_ONE, 24'hFFFFFF);
    write_cfg(CFG_EPSILON, 32'd1);
    send_element(12'h0F0, 32'h0100_0000, 32'h1234_5678, 1'b1);
    send_element(12'h0F1, 32'h8000_0000, 32'h8765_4321, 1'b0);
    wait_drained();

    // back to defaults, random passes with bursts
    write_cfg(CFG_STEP_SIZE, STEP_SIZE_RST);
    write_cfg(CFG_BETA_ONE, BETA_ONE_RST);
    write_cfg(CFG_BETA_TWO, BETA_TWO_RST);
    write_cfg(CFG_EPSILON, EPSILON_RST);
    for (int k = 0; k < 20; k++) train_pass(20);

    // long receiver hold-off while elements keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      train_pass(300);
    join
    wait_drained();

    // random register settings
    write_cfg(CFG_STEP_SIZE, $urandom());
    write_cfg(CFG_BETA_ONE, $urandom());
    write_cfg(CFG_BETA_TWO, $urandom());
    write_cfg(CFG_EPSILON, $urandom_range(0, 1000));
    for (int k = 0; k < 10; k++) train_pass(20);
    wait_drained();
    write_cfg(CFG_STEP_SIZE, 32'h0100_0000);
    write_cfg(CFG_BETA_ONE, 24'hE00000);
    write_cfg(CFG_BETA_TWO, 24'hFF0000);
    write_cfg(CFG_EPSILON, 32'd100);
    for (int k = 0; k < 10; k++) train_pass(18);

    // tail without idling
    quiet_tail = 1'b1;
    for (int k = 0; k < 6; k++) train_pass(20);
    idle_input();

    fork
      begin
        while (sb.pending.size() != 0) @(posedge clk_i);
        repeat (LATENCY + 20) @(posedge clk_i);
      end
      begin
        repeat (IDLE_LIMIT + 200000) @(posedge clk_i);
      end
    join_any
    if (sb.pending.size() != 0) begin
      $display("timeout with %0d results outstanding", sb.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
    if (upd_ch.valid) sb.report_err("result beat after drain", 0, upd_ch.out_index);
    $display("Covered %0d element beats over %0d training steps, %0d results checked,",
             beats_in, step_count, sb.checked);
    $display("with extreme and random register settings and a long output stall.");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/aou_pkg.sv
sv/aou_if.sv
sv/aou_div.sv
sv/aou_sqrt.sv
sv/aou_moment.sv
sv/adam_optimizer_update_core.sv
bench/adam_optimizer_update_core_tb.sv
